>>> sv/tmavg_pkg.sv
// Package for the time offset moving average block.
// Holds field widths, reset values, register indexes and input mode codes.
// No dependencies; every other file of the block imports it or follows it.
package tmavg_pkg;

    localparam int DEF_STORE_DEPTH = 32;

    localparam int VALUE_W    = 32;
    localparam int WINDOW_W   = 6;
    localparam int DRIFT_W    = 8;
    localparam int HELD_OUT_W = 6;
    localparam int CFG_DATA_W = 8;
    localparam int CFG_IDX_W  = 1;

    localparam logic [WINDOW_W-1:0] RESET_WINDOW = 6'd20;
    localparam logic [DRIFT_W-1:0]  RESET_DRIFT  = 8'd20;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WINDOW_SIZE = 1'b0,
        CFG_MAX_DRIFT   = 1'b1
    } cfg_index_t;

    localparam logic MODE_SAMPLE  = 1'b0;
    localparam logic MODE_ELAPSED = 1'b1;

endpackage

>>> sv/tmavg_if.sv
// Channel interfaces for the time offset moving average block.
// One interface for input beats and one for result beats, each with valid and ready.
// No dependencies.
interface tmavg_in_if;
    logic               valid;
    logic               ready;
    logic               mode;
    logic signed [31:0] value;

    modport source (output valid, mode, value, input ready);
    modport sink   (input valid, mode, value, output ready);
endinterface

interface tmavg_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] offset;
    logic               synced;
    logic               clock_jumped;
    logic [5:0]         samples_held;

    modport source (output valid, offset, synced, clock_jumped, samples_held, input ready);
    modport sink   (input valid, offset, synced, clock_jumped, samples_held, output ready);
endinterface

>>> sv/time_offset_moving_average_core.sv
// Time offset moving average core. Each input beat is either a clock offset
// sample (mode 0) or the elapsed seconds measured over one tick (mode 1), and
// each gives exactly one result beat. Samples are kept in a ring held in one
// synchronous memory; while the window is filling a sample is appended, and
// once it is full the sample replaces the oldest entry, which needs an extra
// state (ST_RMW) for the read of the evicted value. The published offset is
// the held sum divided by the held count, rounded half away from zero,
// produced by a restoring divider that resolves one quotient bit per cycle.
// An elapsed beat skips the divider: when it lies outside the drift window
// the ring is emptied and the elapsed value is subtracted from the offset
// with saturation to 32 bits. One item is worked on at a time; the result
// register lets the next item be taken while a finished result still waits
// for the sink. The two configuration registers are written through a plain
// write port and should only be changed while the block is idle.
module time_offset_moving_average_core
    import tmavg_pkg::*;
#(
    parameter int STORE_DEPTH = DEF_STORE_DEPTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    tmavg_in_if.sink              in_ch,
    tmavg_out_if.source           out_ch
);

    // Held count must reach STORE_DEPTH itself; the ring index only needs
    // to address the entries.
    localparam int CNT_W  = $clog2(STORE_DEPTH + 1);
    localparam int IDX_W  = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    // The running sum of up to STORE_DEPTH 32-bit samples, with sign.
    localparam int SUM_W  = VALUE_W + CNT_W;
    // Dividend is 2*|sum| + n, divisor is 2*n.
    localparam int NUM_W  = SUM_W + 1;
    localparam int DEN_W  = CNT_W + 1;
    localparam int REM_W  = DEN_W + 1;
    localparam int DCNT_W = $clog2(NUM_W);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RMW,
        ST_PREP,
        ST_DIV,
        ST_SIGN,
        ST_FINISH
    } state_t;

    // Sample store: one write and one registered read per cycle.
    logic signed [VALUE_W-1:0] mem [STORE_DEPTH];
    logic                      mem_we;
    logic [IDX_W-1:0]          mem_waddr;
    logic signed [VALUE_W-1:0] mem_wdata;
    logic                      mem_re;
    logic [IDX_W-1:0]          mem_raddr;
    logic signed [VALUE_W-1:0] rd_data_reg;

    // Configuration.
    logic [WINDOW_W-1:0] window_reg;
    logic [DRIFT_W-1:0]  drift_reg;

    // Control and arithmetic state.
    state_t                    state_reg, state_next;
    logic [CNT_W-1:0]          held_reg, held_next;
    logic [IDX_W-1:0]          oldest_reg, oldest_next;
    logic signed [SUM_W-1:0]   sum_reg, sum_next;
    logic signed [VALUE_W-1:0] offset_reg, offset_next;
    logic                      synced_reg, synced_next;
    logic                      jump_reg, jump_next;
    logic signed [VALUE_W-1:0] sample_reg, sample_next;
    logic [IDX_W-1:0]          idx_reg, idx_next;
    logic                      neg_reg, neg_next;
    logic [NUM_W-1:0]          num_reg, num_next;
    logic [DEN_W-1:0]          den_reg, den_next;
    logic [REM_W-1:0]          rem_reg, rem_next;
    logic [DCNT_W-1:0]         cnt_reg, cnt_next;

    // Result register.
    logic                      out_valid_reg, out_valid_next;
    logic signed [VALUE_W-1:0] out_offset_reg, out_offset_next;
    logic                      out_synced_reg, out_synced_next;
    logic                      out_jump_reg, out_jump_next;
    logic [HELD_OUT_W-1:0]     out_held_reg, out_held_next;

    // Helpers.
    logic [CNT_W-1:0]          win_eff;
    logic                      in_accept;
    logic [IDX_W-1:0]          repl_idx;
    logic [CNT_W-1:0]          idx_inc;
    logic signed [33:0]        elapsed_ext;
    logic signed [33:0]        drift_hi;
    logic signed [33:0]        drift_lo;
    logic                      is_jump;
    logic signed [32:0]        jump_diff;
    logic signed [VALUE_W-1:0] jump_offset;
    logic [SUM_W-1:0]          sum_mag;
    logic [REM_W-1:0]          rem_shift;
    logic                      rem_ge;
    logic [VALUE_W-1:0]        quot;

    assign in_accept   = in_ch.valid && in_ch.ready;
    assign in_ch.ready = (state_reg == ST_IDLE);

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.offset       = out_offset_reg;
    assign out_ch.synced       = out_synced_reg;
    assign out_ch.clock_jumped = out_jump_reg;
    assign out_ch.samples_held = out_held_reg;

    // A window of zero acts as one, and a window beyond the store as the store.
    always_comb
    begin
        if (window_reg == '0)
        begin
            win_eff = CNT_W'(1);
        end
        else if (32'(window_reg) > 32'(STORE_DEPTH))
        begin
            win_eff = CNT_W'(STORE_DEPTH);
        end
        else
        begin
            win_eff = CNT_W'(window_reg);
        end
    end

    // A stale ring pointer falls back to entry 0.
    assign repl_idx = (CNT_W'(oldest_reg) >= held_reg) ? '0 : oldest_reg;
    assign idx_inc  = CNT_W'(idx_reg) + CNT_W'(1);

    // Drift window: a jump is declared above max_drift + 1 or below 1 - max_drift.
    assign elapsed_ext = 34'(in_ch.value);
    assign drift_hi    = $signed({26'd0, drift_reg}) + 34'sd1;
    assign drift_lo    = 34'sd1 - $signed({26'd0, drift_reg});
    assign is_jump     = (elapsed_ext > drift_hi) || (elapsed_ext < drift_lo);

    assign jump_diff = 33'(offset_reg) - 33'(in_ch.value);
    always_comb
    begin
        if (jump_diff[32] != jump_diff[31])
        begin
            jump_offset = jump_diff[32] ? {1'b1, {(VALUE_W-1){1'b0}}}
                                        : {1'b0, {(VALUE_W-1){1'b1}}};
        end
        else
        begin
            jump_offset = jump_diff[VALUE_W-1:0];
        end
    end

    assign sum_mag = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);

    // One restoring step of the divider.
    assign rem_shift = {rem_reg[REM_W-2:0], num_reg[NUM_W-1]};
    assign rem_ge    = (rem_shift >= REM_W'(den_reg));
    assign quot      = num_reg[VALUE_W-1:0];

    always_comb
    begin
        state_next      = state_reg;
        held_next       = held_reg;
        oldest_next     = oldest_reg;
        sum_next        = sum_reg;
        offset_next     = offset_reg;
        synced_next     = synced_reg;
        jump_next       = jump_reg;
        sample_next     = sample_reg;
        idx_next        = idx_reg;
        neg_next        = neg_reg;
        num_next        = num_reg;
        den_next        = den_reg;
        rem_next        = rem_reg;
        cnt_next        = cnt_reg;
        out_valid_next  = out_valid_reg;
        out_offset_next = out_offset_reg;
        out_synced_next = out_synced_reg;
        out_jump_next   = out_jump_reg;
        out_held_next   = out_held_reg;
        mem_we          = 1'b0;
        mem_waddr       = idx_reg;
        mem_wdata       = sample_reg;
        mem_re          = 1'b0;
        mem_raddr       = repl_idx;

        // The sink taking the waiting beat frees the result register.
        if (out_valid_reg && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    sample_next = in_ch.value;
                    if (in_ch.mode == MODE_ELAPSED)
                    begin
                        jump_next = is_jump;
                        if (is_jump)
                        begin
                            held_next   = '0;
                            sum_next    = '0;
                            oldest_next = '0;
                            offset_next = jump_offset;
                        end
                        state_next = ST_FINISH;
                    end
                    else if (held_reg < win_eff)
                    begin
                        // Window still filling: append at the end of the ring.
                        jump_next  = 1'b0;
                        mem_we     = 1'b1;
                        mem_waddr  = held_reg[IDX_W-1:0];
                        mem_wdata  = in_ch.value;
                        held_next  = held_reg + CNT_W'(1);
                        sum_next   = sum_reg + SUM_W'(in_ch.value);
                        state_next = ST_PREP;
                    end
                    else
                    begin
                        // Window full: fetch the entry about to be evicted.
                        jump_next  = 1'b0;
                        mem_re     = 1'b1;
                        mem_raddr  = repl_idx;
                        idx_next   = repl_idx;
                        state_next = ST_RMW;
                    end
                end
            end

            ST_RMW:
            begin
                sum_next    = sum_reg - SUM_W'(rd_data_reg) + SUM_W'(sample_reg);
                mem_we      = 1'b1;
                mem_waddr   = idx_reg;
                mem_wdata   = sample_reg;
                oldest_next = (idx_inc >= held_reg) ? '0 : idx_inc[IDX_W-1:0];
                state_next  = ST_PREP;
            end

            ST_PREP:
            begin
                neg_next   = sum_reg[SUM_W-1];
                num_next   = {sum_mag, 1'b0} + NUM_W'(held_reg);
                den_next   = {held_reg, 1'b0};
                rem_next   = '0;
                cnt_next   = '0;
                state_next = ST_DIV;
            end

            ST_DIV:
            begin
                rem_next = rem_ge ? (rem_shift - REM_W'(den_reg)) : rem_shift;
                num_next = {num_reg[NUM_W-2:0], rem_ge};
                if (cnt_reg == DCNT_W'(NUM_W - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_SIGN;
                end
                else
                begin
                    cnt_next = cnt_reg + DCNT_W'(1);
                end
            end

            ST_SIGN:
            begin
                offset_next = neg_reg ? VALUE_W'(-quot) : quot;
                synced_next = 1'b1;
                state_next  = ST_FINISH;
            end

            ST_FINISH:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_offset_next = offset_reg;
                    out_synced_next = synced_reg;
                    out_jump_next   = jump_reg;
                    out_held_next   = HELD_OUT_W'(held_reg);
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            window_reg     <= RESET_WINDOW;
            drift_reg      <= RESET_DRIFT;
            held_reg       <= '0;
            oldest_reg     <= '0;
            sum_reg        <= '0;
            offset_reg     <= '0;
            synced_reg     <= 1'b0;
            jump_reg       <= 1'b0;
            neg_reg        <= 1'b0;
            cnt_reg        <= '0;
            out_valid_reg  <= 1'b0;
            out_offset_reg <= '0;
            out_synced_reg <= 1'b0;
            out_jump_reg   <= 1'b0;
            out_held_reg   <= '0;
            sample_reg     <= '0;
            idx_reg        <= '0;
            num_reg        <= '0;
            den_reg        <= '0;
            rem_reg        <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index_t'(cfg_index))
                    CFG_WINDOW_SIZE: window_reg <= cfg_data[WINDOW_W-1:0];
                    CFG_MAX_DRIFT:   drift_reg  <= cfg_data[DRIFT_W-1:0];
                    default:         window_reg <= window_reg;
                endcase
            end
            state_reg      <= state_next;
            held_reg       <= held_next;
            oldest_reg     <= oldest_next;
            sum_reg        <= sum_next;
            offset_reg     <= offset_next;
            synced_reg     <= synced_next;
            jump_reg       <= jump_next;
            neg_reg        <= neg_next;
            cnt_reg        <= cnt_next;
            out_valid_reg  <= out_valid_next;
            out_offset_reg <= out_offset_next;
            out_synced_reg <= out_synced_next;
            out_jump_reg   <= out_jump_next;
            out_held_reg   <= out_held_next;
            sample_reg     <= sample_next;
            idx_reg        <= idx_next;
            num_reg        <= num_next;
            den_reg        <= den_next;
            rem_reg        <= rem_next;
        end
    end

    // The sample store. Only one item is in flight, so the write of an
    // eviction always lands before the next item can read the ring.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

`ifndef NO_ASSERTIONS
    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= CNT_W'(STORE_DEPTH))
        else $error("held count exceeds the store depth");

    a_ring_pointer: assert property (@(posedge clk) disable iff (!rst_n)
        (held_reg == '0) ? (oldest_reg == '0) : (CNT_W'(oldest_reg) < held_reg))
        else $error("ring pointer outside the held entries");

    a_jump_empties: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_jump_reg |-> out_held_reg == '0)
        else $error("clock jump result reports held samples");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> state_reg != ST_IDLE)
        else $error("accepted beat did not start work");

    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_DIV |-> cnt_reg == '0)
        else $error("divider count live outside division");
`endif

endmodule

>>> bench/time_offset_moving_average_core_tb.sv
`timescale 1ns / 100ps

// Self-checking testbench for time_offset_moving_average_core: directed and random
// sample and elapsed beats, checked against an in-bench predictor of the offset.
// Depends on tmavg_pkg and the tmavg_in_if / tmavg_out_if channel interfaces.
module time_offset_moving_average_core_tb;
    import tmavg_pkg::*;

    // Length of the long receiver hold-off that fills the block and stalls its input.
    localparam int HOLD_OFF_CYCLES = 300;
    // Settling time after the last result.
    localparam int DRAIN_CYCLES = 64;

    localparam logic signed [VALUE_W-1:0] INT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [VALUE_W-1:0] INT_MIN = 32'sh8000_0000;

    // One expected result beat.
    typedef struct packed {
        logic signed [VALUE_W-1:0] offset;
        logic                      synced;
        logic                      jumped;
        logic [HELD_OUT_W-1:0]     held;
    } offset_result_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    cfg_index_t            cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    tmavg_in_if  in_ch ();
    tmavg_out_if out_ch ();

    time_offset_moving_average_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    // Predictor state: our own copy of the sample ring, its running sum, the
    // published offset and the two configuration registers.
    logic signed [VALUE_W-1:0] ring [DEF_STORE_DEPTH];
    longint                    ring_sum;
    int                        ring_count;
    int                        ring_oldest;
    logic signed [VALUE_W-1:0] unified_offset;
    logic                      is_synced;
    logic [WINDOW_W-1:0]       window_reg;
    logic [DRIFT_W-1:0]        drift_reg;

    // Results predicted for accepted input beats, oldest first.
    offset_result_t pending_offsets [$];
    int             error_count;

    // Idling controls. tx_idle_on belongs to the sending process; the others are
    // read by the receiver processes and are written with nonblocking assignments.
    bit tx_idle_on;
    bit rx_idle_on;
    bit hold_off_request;
    bit rx_hold;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    task automatic reset_predictor();
        ring_sum       = 0;
        ring_count     = 0;
        ring_oldest    = 0;
        unified_offset = '0;
        is_synced      = 1'b0;
        window_reg     = RESET_WINDOW;
        drift_reg      = RESET_DRIFT;
    endtask

    // Mean of the held samples, rounded half away from zero. The count is
    // always at least one when this is called.
    function automatic logic signed [VALUE_W-1:0] rounded_average(longint sum, int count);
        longint unsigned mag;
        longint unsigned quo;
        longint unsigned n;
        n   = count;
        mag = (sum < 0) ? -sum : sum;
        quo = (mag * 2 + n) / (n * 2);
        return VALUE_W'((sum < 0) ? -longint'(quo) : longint'(quo));
    endfunction

    // Applies one accepted beat to the predictor state and returns the result
    // that the block must give for it.
    function automatic offset_result_t predict_offset(logic mode, logic signed [VALUE_W-1:0] value);
        offset_result_t r;
        int             w;
        int             i;
        longint         e;
        longint         d;
        longint         diff;
        r.jumped = 1'b0;
        if (mode == MODE_SAMPLE)
        begin
            // A window of zero behaves as one; anything beyond the store depth
            // is clamped to it.
            w = window_reg;
            if (w < 1)
                w = 1;
            if (w > DEF_STORE_DEPTH)
                w = DEF_STORE_DEPTH;
            if (ring_count < w)
            begin
                ring[ring_count] = value;
                ring_count++;
            end
            else
            begin
                // Replacement walks over every held entry, even when the window
                // has been shrunk below the held count.
                i = (ring_oldest >= ring_count) ? 0 : ring_oldest;
                ring_sum -= ring[i];
                ring[i] = value;
                i++;
                ring_oldest = (i >= ring_count) ? 0 : i;
            end
            ring_sum += value;
            is_synced = 1'b1;
            unified_offset = rounded_average(ring_sum, ring_count);
        end
        else
        begin
            e = value;
            d = drift_reg;
            // The drift window is asymmetric: (1 - drift) up to (drift + 1).
            if (e > d + 1 || e < 1 - d)
            begin
                ring_count  = 0;
                ring_sum    = 0;
                ring_oldest = 0;
                diff = longint'(unified_offset) - e;
                if (diff > longint'(INT_MAX))
                    diff = INT_MAX;
                if (diff < longint'(INT_MIN))
                    diff = INT_MIN;
                unified_offset = diff[VALUE_W-1:0];
                r.jumped = 1'b1;
            end
        end
        r.offset = unified_offset;
        r.synced = is_synced;
        r.held   = HELD_OUT_W'(ring_count);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Driving helpers
    // ------------------------------------------------------------------

    // Writes one configuration register. Called only while the block is idle,
    // and always at a rising edge.
    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (idx == CFG_WINDOW_SIZE)
            window_reg = data[WINDOW_W-1:0];
        else
            drift_reg = data;
    endtask

    // Offers one input beat and returns at the edge where it is accepted. Valid
    // is left high afterwards, so that back-to-back beats never see it lowered
    // and raised within one time step; drain_block lowers it.
    task automatic send_item(input logic mode, input logic signed [VALUE_W-1:0] value);
        if (tx_idle_on && $urandom_range(0, 4) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.mode  <= mode;
        in_ch.value <= value;
        do
            @(posedge clk);
        while (!in_ch.ready);
        pending_offsets.insert(pending_offsets.size(), predict_offset(mode, value));
    endtask

    // Stops offering beats and waits until every predicted result has come back.
    task automatic drain_block();
        in_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_offsets.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    // One random beat. Mostly samples with varied magnitudes, a good share of
    // elapsed beats inside the drift window, and clock jumps at the given rate
    // so that the ring has room to fill and start replacing between clears.
    task automatic send_random_item(input int jump_pct);
        int                        pick;
        int                        d;
        logic signed [VALUE_W-1:0] v;
        pick = $urandom_range(0, 99);
        d    = drift_reg;
        if (pick < jump_pct)
        begin
            case ($urandom_range(0, 2))
                0:       v = $urandom;
                1:       v = d + 2 + $urandom_range(0, 1000);
                default: v = -d - $urandom_range(0, 1000);
            endcase
            send_item(MODE_ELAPSED, v);
        end
        else if (pick < jump_pct + 25)
        begin
            v = $urandom_range(0, 2 * d) + 1 - d;
            send_item(MODE_ELAPSED, v);
        end
        else
        begin
            case ($urandom_range(0, 7))
                0, 1, 2: v = $urandom;
                3, 4:    v = $urandom_range(0, 4000) - 2000;
                5:       v = INT_MAX - $urandom_range(0, 255);
                6:       v = INT_MIN + $urandom_range(0, 255);
                default: v = $signed($urandom) >>> $urandom_range(0, 31);
            endcase
            send_item(MODE_SAMPLE, v);
        end
    endtask

    // One configuration setting followed by a run of random beats. With idling
    // on, both sides switch their idle bursts on or off every fifty beats so
    // that quiet stretches alternate with busy ones.
    task automatic run_random_phase(input logic [CFG_DATA_W-1:0] window_data,
                                    input logic [CFG_DATA_W-1:0] drift_data,
                                    input int n_items, input int jump_pct,
                                    input bit with_idling);
        write_reg(CFG_WINDOW_SIZE, window_data);
        write_reg(CFG_MAX_DRIFT, drift_data);
        for (int k = 0; k < n_items; k++)
        begin
            if (k % 50 == 0)
            begin
                tx_idle_on = with_idling && $urandom_range(0, 3) != 0;
                rx_idle_on <= with_idling && $urandom_range(0, 3) != 0;
            end
            send_random_item(jump_pct);
        end
        drain_block();
    endtask

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t ns: %s", $time, msg);
        error_count++;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset settings (window 20, drift 20): the edges of the drift window on
    // both sides, elapsed beats before any sample, rounding of a positive half,
    // and saturation of the offset at both ends of its range.
    task automatic test_sample_and_jump_basics();
        send_item(MODE_ELAPSED, 32'sd21);     // upper edge, no jump, not yet synced
        send_item(MODE_ELAPSED, 32'sd22);     // jump, offset becomes -22
        send_item(MODE_ELAPSED, -32'sd19);    // lower edge, no jump
        send_item(MODE_ELAPSED, -32'sd20);    // jump, offset becomes -2
        send_item(MODE_SAMPLE, 32'sd1);
        send_item(MODE_SAMPLE, 32'sd2);       // 1.5 rounds up to 2
        send_item(MODE_SAMPLE, -32'sd9);      // -6 / 3
        send_item(MODE_SAMPLE, INT_MAX);
        send_item(MODE_ELAPSED, INT_MIN);     // offset minus INT_MIN saturates high
        send_item(MODE_SAMPLE, INT_MIN);      // ring was cleared, so the mean is INT_MIN
        send_item(MODE_ELAPSED, INT_MAX);     // saturates low
        drain_block();
    endtask

    // Window of one (each sample after the first replaces), window of zero
    // (behaves as one), a zero drift where only an elapsed value of one is
    // accepted, the widest drift, a window value whose upper data bits must be
    // ignored, and the window being shrunk below and then grown past the held count.
    task automatic test_window_limits();
        write_reg(CFG_WINDOW_SIZE, 8'd1);
        write_reg(CFG_MAX_DRIFT, 8'd0);
        send_item(MODE_SAMPLE, 32'sd100);
        send_item(MODE_SAMPLE, -32'sd100);
        send_item(MODE_ELAPSED, 32'sd1);
        send_item(MODE_ELAPSED, 32'sd0);
        send_item(MODE_ELAPSED, 32'sd2);
        drain_block();

        write_reg(CFG_WINDOW_SIZE, 8'd0);
        write_reg(CFG_MAX_DRIFT, 8'd255);
        send_item(MODE_SAMPLE, 32'sd7);
        send_item(MODE_SAMPLE, -32'sd3);
        send_item(MODE_ELAPSED, -32'sd254);
        send_item(MODE_ELAPSED, -32'sd255);   // just past the lower edge
        drain_block();

        // Only the low six bits count, so this is a window of four.
        write_reg(CFG_WINDOW_SIZE, 8'hC4);
        send_item(MODE_SAMPLE, 32'sd10);
        send_item(MODE_SAMPLE, 32'sd20);
        send_item(MODE_SAMPLE, 32'sd30);
        send_item(MODE_SAMPLE, 32'sd40);
        drain_block();

        // Shrunk to two: both samples replace entries, and all four stay averaged.
        write_reg(CFG_WINDOW_SIZE, 8'd2);
        send_item(MODE_SAMPLE, 32'sd50);
        send_item(MODE_SAMPLE, 32'sd60);
        drain_block();

        // Grown to six: appending picks up again after the fourth entry.
        write_reg(CFG_WINDOW_SIZE, 8'd6);
        send_item(MODE_SAMPLE, 32'sd70);
        drain_block();
    endtask

    // The receiver holds off for a long stretch while the sender keeps offering
    // beats without gaps, so the result register fills and the block stops
    // taking input until the hold is released.
    task automatic test_output_backpressure();
        tx_idle_on = 1'b0;
        hold_off_request <= 1'b1;
        for (int k = 0; k < 24; k++)
            send_item((k % 3 == 0) ? MODE_SAMPLE : MODE_ELAPSED, $urandom_range(0, 40) - 20);
        drain_block();
    endtask

    // Random beats under a spread of settings, the extremes among them.
    task automatic test_random_settings();
        run_random_phase(8'd1,   8'd1,   150, 5, 1'b1);
        run_random_phase(8'd63,  8'd255, 250, 1, 1'b1);
        run_random_phase(8'd0,   8'd0,   120, 4, 1'b1);
        run_random_phase(8'd32,  8'd20,  250, 1, 1'b1);
        run_random_phase(8'hC3,  8'd100, 150, 4, 1'b1);
        run_random_phase(8'd40,  8'd7,   200, 1, 1'b1);
        repeat (2)
            run_random_phase(CFG_DATA_W'($urandom_range(1, 32)),
                             CFG_DATA_W'($urandom_range(0, 255)), 200, 3, 1'b1);
    endtask

    // The last stretch runs at full rate on both sides, back at the reset settings.
    task automatic test_unthrottled_tail();
        run_random_phase(CFG_DATA_W'(RESET_WINDOW), CFG_DATA_W'(RESET_DRIFT), 180, 2, 1'b0);
    endtask

    // ------------------------------------------------------------------
    // Receiver side
    // ------------------------------------------------------------------

    // Ready is dropped in random bursts while idling is on,
    // and held low throughout a requested hold-off.
    initial
    begin : sink_ready
        int stall_left;
        stall_left   = 0;
        out_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (!rst_n || rx_hold)
            begin
                out_ch.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end
            else if (rx_idle_on && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(0, 5);
                out_ch.ready <= 1'b0;
            end
            else
            begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // Counts out the long hold-off once it has been requested.
    initial
    begin : receiver_hold_off
        int held_cycles;
        rx_hold = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_request)
            begin
                hold_off_request <= 1'b0;
                rx_hold <= 1'b1;
                for (held_cycles = 0; held_cycles < HOLD_OFF_CYCLES; held_cycles++)
                    @(posedge clk);
                rx_hold <= 1'b0;
            end
        end
    end

    // Every result beat is compared, field by field, with the oldest prediction.
    always @(posedge clk)
    begin : result_checker
        offset_result_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_offsets.size() == 0)
            begin
                report_mismatch($sformatf("result beat with nothing predicted, offset %0d",
                                          out_ch.offset));
            end
            else
            begin
                want = pending_offsets.pop_front();
                if (out_ch.offset !== want.offset)
                    report_mismatch($sformatf("offset %0d, predicted %0d",
                                              out_ch.offset, want.offset));
                if (out_ch.synced !== want.synced)
                    report_mismatch($sformatf("synced %b, predicted %b",
                                              out_ch.synced, want.synced));
                if (out_ch.clock_jumped !== want.jumped)
                    report_mismatch($sformatf("clock_jumped %b, predicted %b",
                                              out_ch.clock_jumped, want.jumped));
                if (out_ch.samples_held !== want.held)
                    report_mismatch($sformatf("samples_held %0d, predicted %0d",
                                              out_ch.samples_held, want.held));
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = CFG_WINDOW_SIZE;
        cfg_data         = '0;
        in_ch.valid      = 1'b0;
        in_ch.mode       = MODE_SAMPLE;
        in_ch.value      = '0;
        tx_idle_on       = 1'b1;
        rx_idle_on       = 1'b1;
        hold_off_request = 1'b0;
        error_count      = 0;
        reset_predictor();

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_sample_and_jump_basics();
        test_window_limits();
        test_output_backpressure();
        test_random_settings();
        test_unthrottled_tail();

        // Anything the block still emits now would be a stray beat.
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("PASS time_offset_moving_average_core");
        else
            $display("FAIL time_offset_moving_average_core");
        $finish;
    end

    // A correct run takes about a millisecond; this leaves ample margin.
    initial
    begin : run_limit
        #5_000_000;
        $display("FAIL time_offset_moving_average_core");
        $finish;
    end

endmodule
